>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every check samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When ante holds at an edge, cons must hold at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rscp_pkg.sv
// ----------------------------------------------------------------------------
// rscp_pkg
// Shared types and constants of the resizing stack capacity policy unit.
// ----------------------------------------------------------------------------
package rscp_pkg;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned MIN_CAPACITY = 10;

  // The count must hold DEPTH itself; the address only DEPTH - 1.
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned RATIO_W = 7;
  localparam int unsigned PROD_W = CNT_W + RATIO_W;
  localparam int unsigned OCC_W  = CNT_W + PCT_W;
  localparam int unsigned FRAC_W = 4;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  typedef enum logic [1:0] {
    REG_GROW_THRESH   = 2'd0,
    REG_SHRINK_THRESH = 2'd1,
    REG_GROW_RATIO    = 2'd2,
    REG_SHRINK_RATIO  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_code_e;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic                     pop_valid;
    logic [1:0]               error_code;
    logic [10:0]              item_count;
    logic [10:0]              capacity;
    logic [10:0]              max_capacity;
    logic [31:0]              resize_total;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic test;
    logic mul;
    logic apply;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_pop;
    logic empty;
    logic full;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hw/rtl/rscp_ctrl.sv
// ----------------------------------------------------------------------------
// rscp_ctrl
// Sequencer: one item through execute; pushes add test, multiply and apply.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rscp_ctrl import rscp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_TEST  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_APPLY = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        // Only a successful push runs the resize test.
        if (!sts_i.is_pop && !sts_i.full) begin
          state_d = S_TEST;
        end else begin
          state_d = S_DONE;
        end
      end
      S_TEST: begin
        cmd_o.test = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEXT(a_accept_to_exec, in_valid_i && in_ready_o, state_q == S_EXEC,
               "accepted transfer did not start execution")
  `ASSERT_NEXT(a_apply_to_done, state_q == S_APPLY, state_q == S_DONE,
               "resize apply step not followed by result stage")

endmodule

>>> hw/rtl/rscp_dp.sv
// ----------------------------------------------------------------------------
// rscp_dp
// Datapath: stack memory, count, capacity policy arithmetic, config and
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rscp_dp import rscp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  in_item_t         in_item_i,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output out_item_t        out_item_o
);

  localparam int unsigned SC_W = PROD_W - FRAC_W;

  logic [DATA_W-1:0] mem [DEPTH];

  logic                     cmd_q;
  logic signed [DATA_W-1:0] val_q;
  logic [DATA_W-1:0]        rd_data_q;
  logic [CNT_W-1:0]         count_q, cap_q, maxcap_q;
  logic [31:0]              rsz_q;
  logic [PCT_W-1:0]         grow_th_q, shrink_th_q;
  logic [RATIO_W-1:0]       grow_rt_q;
  logic [4:0]               shrink_rt_q;
  logic [1:0]               err_q;
  logic                     popv_q;
  logic                     hit_q;
  logic [RATIO_W-1:0]       ratio_q;
  logic [PROD_W-1:0]        prod_q;
  logic                     out_valid_q;
  out_item_t                out_item_q;

  logic             full, empty;
  logic [OCC_W-1:0] occ, grow_lim, shrink_lim;
  logic [SC_W-1:0]  scaled;
  logic [CNT_W-1:0] new_cap;
  logic [CNT_W-1:0] count_m1;

  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - CNT_W'(1);

  assign sts_o.is_pop   = (cmd_q == CMD_POP);
  assign sts_o.empty    = empty;
  assign sts_o.full     = full;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Occupancy test in whole percent, without division.
  assign occ        = OCC_W'(count_q) * OCC_W'(PCT_FULL);
  assign grow_lim   = OCC_W'(grow_th_q) * OCC_W'(cap_q);
  assign shrink_lim = OCC_W'(shrink_th_q) * OCC_W'(cap_q);

  assign scaled = prod_q[PROD_W-1:FRAC_W];

  always_comb begin
    if (scaled > SC_W'(DEPTH)) begin
      new_cap = CNT_W'(DEPTH);
    end else begin
      new_cap = scaled[CNT_W-1:0];
    end
    if (new_cap < CNT_W'(MIN_CAPACITY)) begin
      new_cap = CNT_W'(MIN_CAPACITY);
    end
    if (new_cap < count_q) begin
      new_cap = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grow_th_q   <= PCT_W'(85);
      shrink_th_q <= PCT_W'(50);
      grow_rt_q   <= RATIO_W'(32);
      shrink_rt_q <= 5'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GROW_THRESH:   grow_th_q   <= cfg_wdata_i[PCT_W-1:0];
        REG_SHRINK_THRESH: shrink_th_q <= cfg_wdata_i[PCT_W-1:0];
        REG_GROW_RATIO:    grow_rt_q   <= cfg_wdata_i[RATIO_W-1:0];
        REG_SHRINK_RATIO:  shrink_rt_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= in_item_i.command;
      val_q <= in_item_i.push_value;
    end
  end

  // Single write port and single registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && cmd_q == CMD_PUSH && !full) begin
      mem[count_q[ADDR_W-1:0]] <= val_q;
    end
    if (cmd_i.exec) begin
      rd_data_q <= mem[count_m1[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cap_q    <= CNT_W'(MIN_CAPACITY);
      maxcap_q <= CNT_W'(MIN_CAPACITY);
      rsz_q    <= '0;
      err_q    <= ERR_OK;
      popv_q   <= 1'b0;
      hit_q    <= 1'b0;
      ratio_q  <= '0;
      prod_q   <= '0;
    end else begin
      if (cmd_i.exec) begin
        popv_q <= 1'b0;
        err_q  <= ERR_OK;
        if (cmd_q == CMD_PUSH) begin
          if (full) begin
            err_q <= ERR_FULL;
          end else begin
            count_q <= count_q + CNT_W'(1);
          end
        end else begin
          if (empty) begin
            err_q <= ERR_EMPTY;
          end else begin
            count_q <= count_m1;
            popv_q  <= 1'b1;
          end
        end
      end
      if (cmd_i.test) begin
        priority if (occ >= grow_lim) begin
          hit_q   <= 1'b1;
          ratio_q <= grow_rt_q;
        end else if (occ <= shrink_lim) begin
          hit_q   <= 1'b1;
          ratio_q <= RATIO_W'(shrink_rt_q);
        end else begin
          hit_q   <= 1'b0;
          ratio_q <= grow_rt_q;
        end
      end
      if (cmd_i.mul) begin
        prod_q <= PROD_W'(cap_q) * PROD_W'(ratio_q);
      end
      if (cmd_i.apply && hit_q) begin
        cap_q <= new_cap;
        if (new_cap > maxcap_q) begin
          maxcap_q <= new_cap;
        end
        if (rsz_q != '1) begin
          rsz_q <= rsz_q + 32'd1;
        end
      end
    end
  end

  // Result register: the next item may run while this one waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q.pop_value    <= popv_q ? signed'(rd_data_q) : '0;
      out_item_q.pop_valid    <= popv_q;
      out_item_q.error_code   <= err_q;
      out_item_q.item_count   <= 11'(count_q);
      out_item_q.capacity     <= 11'(cap_q);
      out_item_q.max_capacity <= 11'(maxcap_q);
      out_item_q.resize_total <= rsz_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_CLK(a_count_bound, count_q <= CNT_W'(DEPTH), "stack count exceeds memory depth")
  `ASSERT_CLK(a_cap_bound,
              cap_q >= CNT_W'(MIN_CAPACITY) && cap_q <= CNT_W'(DEPTH) && maxcap_q >= cap_q,
              "capacity outside bounds or above tracked maximum")
  `ASSERT_CLK(a_err_popv, !(popv_q && err_q != ERR_OK), "pop result flagged with an error")

endmodule

>>> hw/rtl/resizing_stack_capacity_policy_unit.sv
// An accepted push steps through the execute, resize test, multiply, apply
// and result states before its result transfer is offered; a pop or a
// rejected item goes from execute straight to the result state. Items go one
// at a time: the next is accepted once the last is in the result register.
// Reset: asynchronous, active low; count and resize total clear, capacity and
// maximum capacity return to 10, registers return to 85/50/32/8.
// ----------------------------------------------------------------------------
// resizing_stack_capacity_policy_unit
// LIFO stack with a threshold-driven logical capacity and resize statistics.
// ----------------------------------------------------------------------------
module resizing_stack_capacity_policy_unit import rscp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  rscp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  rscp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives push and pop transfers into the resizing stack capacity policy unit
// through random gaps and receiver stalls. Each result is checked field by
// field against a cycle-free predictor of the stack, its logical capacity and
// its resize statistics, across several policy register settings.
// ----------------------------------------------------------------------------
module testbench;
  import rscp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 400;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = REG_GROW_THRESH;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  in_item_t         in_item_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_item_o;

  resizing_stack_capacity_policy_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: the stack image, its occupancy and the capacity policy.
  logic [31:0]  stack_image [DEPTH];
  int unsigned  depth_now = 0;
  int unsigned  cap_now = MIN_CAPACITY;
  int unsigned  cap_peak = MIN_CAPACITY;
  logic [31:0]  resize_tally = '0;
  logic [6:0]   grow_pct = 7'd85;
  logic [6:0]   shrink_pct = 7'd50;
  logic [6:0]   grow_ratio = 7'd32;
  logic [4:0]   shrink_ratio = 5'd8;

  in_item_t     pending_ops [$];
  out_item_t    stack_reports_due [$];
  int unsigned  gen_depth = 0;
  int unsigned  mismatches = 0;
  int unsigned  send_gap = 0;
  int unsigned  send_calm = 0;
  int unsigned  recv_stall = 0;
  int unsigned  recv_calm = 0;
  int unsigned  reports_seen = 0;
  int unsigned  quiet_cycles = 0;

  // Most gaps are short; now and then a calm stretch of back-to-back transfers.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (pick < 3) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void step_stack_policy(in_item_t op);
    out_item_t    rep;
    longint unsigned occupancy;
    longint unsigned scaled;
    logic [6:0]   ratio;
    bit           resize;
    rep = '0;
    rep.error_code = ERR_OK;
    if (op.command == CMD_PUSH) begin
      if (depth_now >= DEPTH) begin
        rep.error_code = ERR_FULL;
      end else begin
        stack_image[depth_now] = op.push_value;
        depth_now++;
        occupancy = longint'(depth_now) * 100;
        resize = 1'b1;
        ratio = '0;
        if (occupancy >= longint'(grow_pct) * cap_now) begin
          ratio = grow_ratio;
        end else if (occupancy <= longint'(shrink_pct) * cap_now) begin
          ratio = 7'(shrink_ratio);
        end else begin
          resize = 1'b0;
        end
        if (resize) begin
          scaled = (longint'(cap_now) * ratio) >> 4;
          if (scaled > DEPTH) scaled = DEPTH;
          if (scaled < MIN_CAPACITY) scaled = MIN_CAPACITY;
          if (scaled < depth_now) scaled = depth_now;
          cap_now = int'(scaled);
          if (cap_now > cap_peak) cap_peak = cap_now;
          if (resize_tally != '1) resize_tally++;
        end
      end
    end else if (depth_now == 0) begin
      rep.error_code = ERR_EMPTY;
    end else begin
      depth_now--;
      rep.pop_value = stack_image[depth_now];
      rep.pop_valid = 1'b1;
    end
    rep.item_count   = 11'(depth_now);
    rep.capacity     = 11'(cap_now);
    rep.max_capacity = 11'(cap_peak);
    rep.resize_total = resize_tally;
    stack_reports_due.push_back(rep);
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Sender: a new item is launched once the previous one has been taken and its random gap has passed.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) step_stack_policy(in_item_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_item_i <= pending_ops.pop_front();
          in_valid_i <= 1'b1;
          send_gap = draw_gap(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer and stalls at random; twice it holds
  // off long enough for the unit to back up into its input.
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        reports_seen++;
        if (stack_reports_due.size() == 0) begin
          $error("result transfer with no item outstanding");
          mismatches++;
        end else begin
          want = stack_reports_due.pop_front();
          compare_field("pop_value", want.pop_value, out_item_o.pop_value);
          compare_field("pop_valid", want.pop_valid, out_item_o.pop_valid);
          compare_field("error_code", want.error_code, out_item_o.error_code);
          compare_field("item_count", want.item_count, out_item_o.item_count);
          compare_field("capacity", want.capacity, out_item_o.capacity);
          compare_field("max_capacity", want.max_capacity, out_item_o.max_capacity);
          compare_field("resize_total", want.resize_total, out_item_o.resize_total);
        end
        if (reports_seen == 300 || reports_seen == 1200) recv_stall = LONG_HOLD;
        else recv_stall = draw_gap(recv_calm);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_ready_i <= (recv_stall == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("resizing_stack_capacity_policy_unit: mismatch");
        $finish;
      end
    end
  end

  task automatic queue_item(logic cmd, logic [31:0] value);
    in_item_t op;
    op.command = cmd;
    op.push_value = value;
    pending_ops.push_back(op);
    if (cmd == CMD_PUSH && gen_depth < DEPTH) gen_depth++;
    if (cmd == CMD_POP && gen_depth > 0) gen_depth--;
  endtask

  task automatic queue_ops(int unsigned n, int unsigned pop_pct);
    repeat (n) begin
      queue_item(($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_PUSH, $urandom());
    end
  endtask

  // Waits until every outstanding item has produced its result, then idles
  // while the pipeline drains.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_ops.size() > 0 || in_valid_i || stack_reports_due.size() > 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic apply_policy(logic [6:0] g_pct, logic [6:0] s_pct, logic [6:0] g_ratio,
                              logic [6:0] s_ratio);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_GROW_THRESH;
    cfg_wdata_i <= g_pct;
    @(posedge clk_i);
    cfg_idx_i <= REG_SHRINK_THRESH;
    cfg_wdata_i <= s_pct;
    @(posedge clk_i);
    cfg_idx_i <= REG_GROW_RATIO;
    cfg_wdata_i <= g_ratio;
    @(posedge clk_i);
    cfg_idx_i <= REG_SHRINK_RATIO;
    cfg_wdata_i <= s_ratio;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grow_pct = g_pct;
    shrink_pct = s_pct;
    grow_ratio = g_ratio;
    shrink_ratio = s_ratio[4:0];
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening under the reset policy: pop on empty, extreme values,
    // a shrink that leaves the capacity at its floor, then growth near full.
    queue_item(CMD_POP, 32'hFFFF_FFFF);
    queue_item(CMD_PUSH, 32'h8000_0000);
    queue_item(CMD_PUSH, 32'h7FFF_FFFF);
    queue_item(CMD_PUSH, 32'hFFFF_FFFF);
    queue_item(CMD_PUSH, 32'h0000_0000);
    queue_item(CMD_PUSH, 32'hA5A5_A5A5);
    queue_item(CMD_POP, 32'h0000_0000);
    queue_item(CMD_PUSH, 32'h5A5A_5A5A);
    queue_item(CMD_PUSH, 32'h0000_0001);
    queue_item(CMD_PUSH, 32'hFFFF_FFFE);
    queue_item(CMD_PUSH, 32'h8000_0001);
    queue_item(CMD_PUSH, 32'h7FFF_FFFE);
    queue_item(CMD_PUSH, 32'h1234_5678);
    repeat (3) queue_item(CMD_POP, $urandom());
    settle();

    // Grow threshold zero: every push resizes, by a ratio of exactly one.
    apply_policy(7'd0, 7'd0, 7'd16, 7'd1);
    queue_ops(150, 45);
    settle();

    // Highest stated thresholds and ratios.
    apply_policy(7'd100, 7'd100, 7'd64, 7'd16);
    queue_ops(150, 45);
    settle();

    // Grow threshold above 100 percent lets the count pass the capacity; the
    // shrink ratio write carries upper bits that the register drops.
    apply_policy(7'd127, 7'd0, 7'd127, 7'h60);
    queue_ops(150, 40);
    settle();

    // Fill the memory to the top, then push against a full stack.
    apply_policy(7'd85, 7'd50, 7'd32, 7'd8);
    while (gen_depth < DEPTH) begin
      queue_item(($urandom_range(0, 31) == 0) ? CMD_POP : CMD_PUSH, $urandom());
    end
    repeat (6) queue_item(CMD_PUSH, $urandom());
    settle();

    // Drain under random policies.
    apply_policy(7'($urandom_range(60, 100)), 7'($urandom_range(0, 60)),
                 7'($urandom_range(16, 64)), 7'($urandom_range(1, 16)));
    queue_ops(225, 75);
    settle();
    apply_policy(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)), 7'($urandom_range(0, 31)));
    queue_ops(225, 70);
    settle();

    if (mismatches == 0 && stack_reports_due.size() == 0) begin
      $display("resizing_stack_capacity_policy_unit: match");
    end else begin
      $display("resizing_stack_capacity_policy_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rscp_pkg.sv
hw/rtl/rscp_ctrl.sv
hw/rtl/rscp_dp.sv
hw/rtl/resizing_stack_capacity_policy_unit.sv
test/testbench.sv
